@@ hw/rtl/rar_pkg.sv @@
// shared types and codes for the rational arithmetic reduce unit
`default_nettype none
package rar_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_DIV = 2'd2;
    localparam logic [1:0] OP_POW = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;

    // divider request / response between sequencer and shared divider
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
        logic [32:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/rar_div.sv @@
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module rar_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rar_pkg::div_req_t req,
    output rar_pkg::div_rsp_t     rsp
);
    import rar_pkg::*;

    logic [32:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [32:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[32]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[32]};
                quo_next = {quo_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

@@ hw/rtl/rational_arith_reduce_unit.sv @@
// top level: fraction arithmetic with gcd reduction over a shared divider
//
// usage: one input beat on s_axis carries op, two fractions and an exponent;
// one result beat on m_axis carries the reduced fraction and a status code.
// add, subtract and divide cross-multiply (one 16x15 product per cycle),
// then reduce by euclid's gcd on a shared 33-bit restoring divider; each
// remainder step is one division, and two final divisions by the gcd
// follow. power first reduces the fraction by the gcd, then multiplies
// up to 15 times per part with a limit check after each step; the
// block takes one item at a time and s_axis_tready is low meanwhile.
// zero denominators and zero divisors are reported at once with status 1.
// the result sits in an output register; while the receiver stalls it
// holds and no new item is taken. reset empties the output and returns
// the sequencer to idle.
`default_nettype none
module rational_arith_reduce_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[1:0], a_num[17:2], a_den[32:18], b_num[48:33], b_den[63:49],
    // exponent[67:64], zero fill to 72
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // res_num[31:0], res_den[62:32], status[64:63], zero fill to 72
    output logic [71:0]      m_axis_tdata
);
    import rar_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_GCD  = 4'd3;
    localparam logic [3:0] S_GWT  = 4'd4;
    localparam logic [3:0] S_DN   = 4'd5;
    localparam logic [3:0] S_DNW  = 4'd6;
    localparam logic [3:0] S_DD   = 4'd7;
    localparam logic [3:0] S_DDW  = 4'd8;
    localparam logic [3:0] S_PWN  = 4'd9;
    localparam logic [3:0] S_PWD  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic signed [15:0] an_reg, an_next, bn_reg, bn_next;
    logic [14:0] ad_reg, ad_next, bd_reg, bd_next;
    logic [3:0]  e_reg, e_next, cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [32:0] m_reg, m_next;     // numerator magnitude
    logic [32:0] d_reg, d_next;     // denominator
    logic [32:0] x_reg, x_next, y_reg, y_next; // gcd pair / power base
    logic [32:0] t1_reg, t1_next;
    logic [32:0] pw_reg, pw_next;
    logic        ovf_reg, ovf_next;
    logic [64:0] res_reg, res_next;
    logic        pow_reg, pow_next;

    div_req_t dreq;
    div_rsp_t drsp;

    rar_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic signed [31:0] prod_s;
    logic signed [15:0] mul_a;
    logic [14:0]        mul_b;
    logic [65:0]        pprod;
    logic signed [33:0] sum;
    logic [32:0]        nmag;
    logic               in_bad;
    logic [32:0]        lim;

    assign prod_s = mul_a * $signed({1'b0, mul_b});
    assign pprod  = pw_reg * x_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; an_next = an_reg; ad_next = ad_reg;
        bn_next = bn_reg; bd_next = bd_reg; e_next = e_reg;
        cnt_next = cnt_reg; neg_next = neg_reg; m_next = m_reg;
        d_next = d_reg; x_next = x_reg; y_next = y_reg;
        t1_next = t1_reg; pw_next = pw_reg; ovf_next = ovf_reg;
        res_next = res_reg; pow_next = pow_reg;
        dreq = '0;
        mul_a = an_reg;
        mul_b = bd_reg;
        sum = '0;
        nmag = '0;
        lim = 33'h7FFFFFFF;
        in_bad = 1'b0;
        s_axis_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next = s_axis_tdata[1:0];
                    an_next = s_axis_tdata[17:2];
                    ad_next = s_axis_tdata[32:18];
                    bn_next = s_axis_tdata[48:33];
                    bd_next = s_axis_tdata[63:49];
                    e_next  = s_axis_tdata[67:64];
                    in_bad  = (s_axis_tdata[32:18] == '0)
                        || (s_axis_tdata[1:0] != OP_POW && s_axis_tdata[63:49] == '0)
                        || (s_axis_tdata[1:0] == OP_DIV && s_axis_tdata[48:33] == '0);
                    if (in_bad)
                    begin
                        res_next = {ST_ZERO, 63'd0};
                        state_next = S_OUT;
                    end
                    else if (s_axis_tdata[1:0] == OP_POW)
                    begin
                        pow_next = 1'b1;
                        x_next = s_axis_tdata[17] ? 33'(-$signed({{17{1'b1}},
                            s_axis_tdata[17:2]})) : {17'd0, s_axis_tdata[17:2]};
                        m_next = x_next;
                        d_next = {18'd0, s_axis_tdata[32:18]};
                        y_next = d_next;
                        neg_next = s_axis_tdata[17] & s_axis_tdata[64];
                        state_next = S_GCD;
                    end
                    else
                    begin
                        pow_next = 1'b0;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
                t1_next = 33'(signed'(prod_s));
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (op_reg == OP_DIV)
                begin
                    // num = a_num*b_den, negated if b_num < 0; den = a_den*|b_num|
                    mul_a = bn_reg[15] ? 16'(-bn_reg) : bn_reg;
                    mul_b = ad_reg;
                    sum = bn_reg[15] ? -34'(signed'(t1_reg)) : 34'(signed'(t1_reg));
                    d_next = (bn_reg == 16'sh8000) ? {1'b0, 32'd32768 * {17'd0, ad_reg}}
                                                   : 33'(unsigned'(prod_s));
                end
                else
                begin
                    mul_a = bn_reg;
                    mul_b = ad_reg;
                    sum = (op_reg == OP_ADD)
                        ? 34'(signed'(t1_reg)) + 34'(signed'(prod_s))
                        : 34'(signed'(t1_reg)) - 34'(signed'(prod_s));
                    d_next = {18'd0, ad_reg} * {18'd0, bd_reg};
                end
                nmag = sum[33] ? 33'(-sum) : sum[32:0];
                neg_next = sum[33];
                m_next = nmag;
                x_next = nmag;
                y_next = d_next;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (y_reg == '0)
                begin
                    // x holds gcd; zero only when both are zero (not reachable)
                    state_next = S_DN;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = x_reg;
                    dreq.divisor = y_reg;
                    state_next = S_GWT;
                end
            end
            S_GWT:
            begin
                if (drsp.done)
                begin
                    x_next = y_reg;
                    y_next = drsp.rem;
                    state_next = S_GCD;
                end
            end
            S_DN:
            begin
                dreq.start = 1'b1;
                dreq.dividend = m_reg;
                dreq.divisor = x_reg;
                state_next = S_DNW;
            end
            S_DNW:
            begin
                if (drsp.done)
                begin
                    m_next = drsp.quot;
                    state_next = S_DD;
                end
            end
            S_DD:
            begin
                dreq.start = 1'b1;
                dreq.dividend = d_reg;
                dreq.divisor = x_reg;
                state_next = S_DDW;
            end
            S_DDW:
            begin
                if (drsp.done)
                begin
                    d_next = drsp.quot;
                    if (pow_reg)
                    begin
                        x_next = m_reg;
                        pw_next = 33'd1;
                        cnt_next = e_reg;
                        ovf_next = 1'b0;
                        state_next = S_PWN;
                    end
                    else
                    begin
                        res_next = {ST_OK,
                            (m_reg == '0) ? 31'd1 : drsp.quot[30:0],
                            neg_reg ? 32'(-m_reg) : m_reg[31:0]};
                        state_next = S_OUT;
                    end
                end
            end
            S_PWN:
            begin
                lim = neg_reg ? 33'h80000000 : 33'h7FFFFFFF;
                if (cnt_reg == '0)
                begin
                    m_next = pw_reg;
                    x_next = d_reg;
                    pw_next = 33'd1;
                    cnt_next = e_reg;
                    state_next = S_PWD;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                    if (pprod > {33'd0, lim})
                        ovf_next = 1'b1;
                    else
                        pw_next = pprod[32:0];
                end
            end
            S_PWD:
            begin
                if (cnt_reg == '0)
                begin
                    if (ovf_reg)
                        res_next = {ST_OVFL, 63'd0};
                    else
                        res_next = {ST_OK,
                            (m_reg == '0) ? 31'd1 : pw_reg[30:0],
                            neg_reg ? 32'(-m_reg) : m_reg[31:0]};
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                    if (pprod > 66'h7FFFFFFF)
                        ovf_next = 1'b1;
                    else
                        pw_next = pprod[32:0];
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; an_reg <= an_next; ad_reg <= ad_next;
        bn_reg <= bn_next; bd_reg <= bd_next; e_reg <= e_next;
        cnt_reg <= cnt_next; neg_reg <= neg_next; m_reg <= m_next;
        d_reg <= d_next; x_reg <= x_next; y_reg <= y_next;
        t1_reg <= t1_next; pw_reg <= pw_next; ovf_reg <= ovf_next;
        res_reg <= res_next; pow_reg <= pow_next;
    end

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {7'd0, res_reg};
endmodule
`default_nettype wire

@@ tb/sv/rational_arith_reduce_unit_tb.sv @@
// testbench for the rational arithmetic reduce unit: directed and random fractions
`default_nettype none
module rational_arith_reduce_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rar_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] a_num;
        logic [14:0] a_den;
        logic [15:0] b_num;
        logic [14:0] b_den;
        logic [3:0]  exponent;
    } frac_op_t;

    typedef struct {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic [1:0]  status;
    } frac_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    frac_res_t   pending_results[$];
    int          mismatches = 0;
    int          stray_beats = 0;
    int          hold_off_cycles = 0;
    bit          rx_stall_on = 1'b1;

    always #4 clk = ~clk;

    rational_arith_reduce_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // raise m to e, gives 0 flag on passing limit
    function automatic bit raise_bounded(longint unsigned m, int e, longint unsigned lim,
                                         output longint unsigned r);
        r = 1;
        for (int i = 0; i < e; i++)
        begin
            r = r * m;
            if (r > lim)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected reduced fraction for one operation
    function automatic frac_res_t reduce_fraction(frac_op_t it);
        frac_res_t       r;
        longint          an, bn, num, t1, t2;
        longint unsigned ad, bd, den, g, m, pn, pd;
        bit              neg, ok_n, ok_d;
        an = longint'($signed(it.a_num));
        bn = longint'($signed(it.b_num));
        ad = it.a_den;
        bd = it.b_den;
        r.res_num = '0;
        r.res_den = '0;
        if (ad == 0 || (it.op != OP_POW && bd == 0) || (it.op == OP_DIV && bn == 0))
        begin
            r.status = ST_ZERO;
            return r;
        end
        if (it.op == OP_POW)
        begin
            m = (an < 0) ? -an : an;
            g = gcd64(m, ad);
            m = m / g;
            ad = ad / g;
            neg = (an < 0) && it.exponent[0];
            ok_n = raise_bounded(m, it.exponent, neg ? 64'd2147483648 : 64'd2147483647, pn);
            ok_d = raise_bounded(ad, it.exponent, 64'd2147483647, pd);
            if (!ok_n || !ok_d)
            begin
                r.status = ST_OVFL;
                return r;
            end
            if (pn == 0)
                pd = 1;
            num = neg ? -longint'(pn) : longint'(pn);
            r.res_num = num[31:0];
            r.res_den = pd[30:0];
            r.status = ST_OK;
            return r;
        end
        if (it.op == OP_DIV)
        begin
            num = an * longint'(bd);
            den = ad * ((bn < 0) ? -bn : bn);
            if (bn < 0)
                num = -num;
        end
        else
        begin
            t1 = an * longint'(bd);
            t2 = bn * longint'(ad);
            num = (it.op == OP_ADD) ? t1 + t2 : t1 - t2;
            den = ad * bd;
        end
        m = (num < 0) ? -num : num;
        g = gcd64(m, den);
        m = m / g;
        den = den / g;
        if (m == 0)
            den = 1;
        num = (num < 0) ? -longint'(m) : longint'(m);
        r.res_num = num[31:0];
        r.res_den = den[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    // sends one beat, predicts its result when accepted
    task automatic send_fraction_op(frac_op_t it);
        s_axis_tdata = {4'b0, it.exponent, it.b_den, it.b_num, it.a_den, it.a_num, it.op};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(reduce_fraction(it));
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // random gaps between bursts of beats
    int burst_left = 0;
    task automatic sender_gap();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
        burst_left--;
    endtask

    function automatic frac_op_t random_op();
        frac_op_t it;
        it.op = 2'($urandom_range(0, 3));
        it.a_num = 16'($urandom);
        it.b_num = 16'($urandom);
        it.a_den = 15'($urandom);
        it.b_den = 15'($urandom);
        it.exponent = 4'($urandom);
        case ($urandom_range(0, 5))
            0:
            begin
                it.a_num = 16'($urandom_range(0, 40) - 20);
                it.a_den = 15'($urandom_range(1, 30));
                it.b_num = 16'($urandom_range(0, 40) - 20);
                it.b_den = 15'($urandom_range(1, 30));
            end
            1:
            begin
                it.a_den = 0;
            end
            2:
            begin
                it.b_num = 0;
            end
            3:
            begin
                it.b_den = 15'($urandom_range(0, 3));
            end
            default:
            begin
            end
        endcase
        if (it.op == OP_POW && $urandom_range(0, 1))
        begin
            it.a_num = 16'($urandom_range(0, 64) - 32);
            it.a_den = 15'($urandom_range(1, 40));
        end
        return it;
    endfunction

    // receiver stall pattern, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_stall_on)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge clk)
    begin
        frac_res_t want;
        frac_res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.res_num = m_axis_tdata[31:0];
            got.res_den = m_axis_tdata[62:32];
            got.status  = m_axis_tdata[64:63];
            if (pending_results.size() == 0)
            begin
                stray_beats++;
                if (mismatches < 10)
                    $display("unexpected result beat %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.res_num !== want.res_num || got.res_den !== want.res_den
                    || got.status !== want.status)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
                                 $signed(want.res_num), want.res_den, want.status,
                                 $signed(got.res_num), got.res_den, got.status);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed();
        frac_op_t d[$];
        // extremes of add, subtract and divide
        d.push_back('{OP_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7fff, 4'h0});
        d.push_back('{OP_ADD, 16'h8000, 15'h7fff, 16'h8000, 15'h1, 4'hf});
        d.push_back('{OP_SUB, 16'h8000, 15'h1, 16'h7fff, 15'h7fff, 4'h0});
        d.push_back('{OP_SUB, 16'd3, 15'd4, 16'd3, 15'd4, 4'h0});
        d.push_back('{OP_DIV, 16'h8000, 15'h7fff, 16'hffff, 15'h1, 4'h0});
        d.push_back('{OP_DIV, 16'd6, 15'd9, 16'hfffe, 15'd3, 4'h0});
        // zero denominators and zero divisor
        d.push_back('{OP_ADD, 16'd1, 15'd0, 16'd1, 15'd1, 4'h0});
        d.push_back('{OP_SUB, 16'd1, 15'd1, 16'd1, 15'd0, 4'h0});
        d.push_back('{OP_DIV, 16'd5, 15'd7, 16'd0, 15'd3, 4'h0});
        d.push_back('{OP_POW, 16'd2, 15'd0, 16'd0, 15'd0, 4'h3});
        // zero numerator result
        d.push_back('{OP_ADD, 16'd0, 15'd5, 16'd0, 15'd9, 4'h0});
        d.push_back('{OP_DIV, 16'd0, 15'd5, 16'd3, 15'd9, 4'h0});
        // power: zero exponent, zero base, reduction, sign, overflow edges
        d.push_back('{OP_POW, 16'd0, 15'd7, 16'hffff, 15'h7fff, 4'h0});
        d.push_back('{OP_POW, 16'd0, 15'd7, 16'd0, 15'd0, 4'h5});
        d.push_back('{OP_POW, 16'd6, 15'd4, 16'd0, 15'd0, 4'hf});
        d.push_back('{OP_POW, 16'hfffe, 15'd1, 16'd0, 15'd0, 4'hf});
        d.push_back('{OP_POW, 16'hfffe, 15'd1, 16'd0, 15'd0, 4'he});
        d.push_back('{OP_POW, 16'h8000, 15'd1, 16'd0, 15'd0, 4'h3});
        d.push_back('{OP_POW, 16'h8000, 15'd1, 16'd0, 15'd0, 4'h2});
        d.push_back('{OP_POW, 16'd1, 15'h7fff, 16'd0, 15'd0, 4'h2});
        d.push_back('{OP_POW, 16'd1, 15'h7fff, 16'd0, 15'd0, 4'h3});
        foreach (d[i])
            send_fraction_op(d[i]);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            sender_gap();
            send_fraction_op(random_op());
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_off_cycles = 3000;
        for (int i = 0; i < 20; i++)
            send_fraction_op(random_op());
    endtask

    // receiver never stalls
    task automatic test_full_rate();
        rx_stall_on = 1'b0;
        for (int i = 0; i < 60; i++)
            send_fraction_op(random_op());
        rx_stall_on = 1'b1;
    endtask

    initial
    begin
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_full_rate();
        test_backpressure();
        test_random(650);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2000)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // worst case: ~750 items, with stalls
    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
